// ===== rtl/core/byte_stream_tokenizer_core_defines.svh =====
// Assertion macros shared by the tokenizer RTL.
// With NO_ASSERTIONS set, every macro expands to nothing.
`ifndef BYTE_STREAM_TOKENIZER_CORE_DEFINES_SVH
`define BYTE_STREAM_TOKENIZER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// When pre holds at a clock edge, post must hold at the same edge.
`define BTOK_ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("btok: implication check failed");

// When pre holds at a clock edge, post must hold at the next edge.
`define BTOK_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("btok: next-cycle check failed");

`else

`define BTOK_ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define BTOK_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// ===== rtl/core/btok_pkg.sv =====
package btok_pkg;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Character constants.
    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;

    // Token kinds as they appear on the result channel.
    typedef enum logic [4:0] {
        K_ID     = 5'd0,
        K_INT    = 5'd1,
        K_EQUALS = 5'd2,
        K_ARROW  = 5'd3,
        K_LPAREN = 5'd4,
        K_RPAREN = 5'd5,
        K_LBRACE = 5'd6,
        K_RBRACE = 5'd7,
        K_LBRACK = 5'd8,
        K_RBRACK = 5'd9,
        K_COLON  = 5'd10,
        K_COMMA  = 5'd11,
        K_GT     = 5'd12,
        K_LT     = 5'd13,
        K_SEMI   = 5'd14,
        K_EOF    = 5'd15,
        K_ERROR  = 5'd16
    } kind_t;

    // Lexer modes.
    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_ID   = 3'd1,
        MODE_INT  = 3'd2,
        MODE_EQ   = 3'd3,
        MODE_ERR  = 3'd4
    } mode_t;

    // One result beat.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] tok_char;
        logic       token_last;
        logic       burst_last;
    } result_t;

    // Lookup of a single-character punctuator.
    typedef struct packed {
        logic  hit;
        kind_t kind;
    } punct_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic punct_t punct_lookup(input logic [7:0] c);
        punct_t p;
        p.hit  = 1'b1;
        p.kind = K_ERROR;
        unique case (c)
            8'h28:   p.kind = K_LPAREN;
            8'h29:   p.kind = K_RPAREN;
            8'h7B:   p.kind = K_LBRACE;
            8'h7D:   p.kind = K_RBRACE;
            8'h5B:   p.kind = K_LBRACK;
            8'h5D:   p.kind = K_RBRACK;
            8'h3A:   p.kind = K_COLON;
            8'h2C:   p.kind = K_COMMA;
            8'h3E:   p.kind = K_GT;
            8'h3C:   p.kind = K_LT;
            8'h3B:   p.kind = K_SEMI;
            default: p.hit  = 1'b0;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/core/btok_fifo.sv =====
`include "byte_stream_tokenizer_core_defines.svh"

module btok_fifo
    import btok_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_n,
    input  result_t    push_data0,
    input  result_t    push_data1,
    output logic       room_two,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_data
);

    result_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                    pop;

    // Room is judged on the registered count only, so ready has no path from the sink.
    assign room_two  = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage: up to two entries written per cycle, in order.
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push_data0;
        end
        if (push_n == 2'd2) begin
            mem_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= push_data1;
        end
    end

    `BTOK_ASSERT_IMPLIES(a_count_bound, aclk, aresetn, 1'b1,
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
    `BTOK_ASSERT_IMPLIES(a_push_needs_room, aclk, aresetn, push_n != 2'd0, room_two)

endmodule

// ===== rtl/core/btok_lexer.sv =====
`include "byte_stream_tokenizer_core_defines.svh"

module btok_lexer
    import btok_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  logic [7:0] ch,
    output logic [1:0] push_n,
    output result_t    res0,
    output result_t    res1
);

    mode_t       mode_reg, mode_next;
    logic [7:0]  held_reg, held_next;

    // Outcome of treating ch as the first byte after idle.
    logic        idle_emit;
    result_t     idle_res;
    mode_t       idle_mode;
    logic [7:0]  idle_held;
    punct_t      pk;
    logic        is_ws;
    logic        word_char;
    logic [1:0]  raw_n;
    result_t     raw0, raw1;

    assign pk        = punct_lookup(ch);
    assign is_ws     = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
    assign word_char = is_letter(ch) || is_digit(ch);

    // Idle classification of the incoming byte.
    always_comb begin
        idle_emit = 1'b0;
        idle_res  = '{kind: K_EOF, tok_char: 8'h00, token_last: 1'b1, burst_last: 1'b0};
        idle_mode = MODE_IDLE;
        idle_held = 8'h00;
        priority if (ch == CH_END) begin
            idle_emit = 1'b1;
        end else if (is_ws) begin
            idle_emit = 1'b0;
        end else if (is_letter(ch)) begin
            idle_mode = MODE_ID;
            idle_held = ch;
        end else if (is_digit(ch)) begin
            idle_mode = MODE_INT;
            idle_held = ch;
        end else if (ch == CH_EQ) begin
            idle_mode = MODE_EQ;
            idle_held = ch;
        end else if (pk.hit) begin
            idle_emit         = 1'b1;
            idle_res.kind     = pk.kind;
            idle_res.tok_char = ch;
        end else begin
            idle_emit     = 1'b1;
            idle_res.kind = K_ERROR;
            idle_mode     = MODE_ERR;
        end
    end

    // Next mode and held character.
    always_comb begin
        mode_next = idle_mode;
        held_next = idle_held;
        unique case (mode_reg)
            MODE_ID: begin
                if (word_char) begin
                    mode_next = MODE_ID;
                    held_next = ch;
                end
            end
            MODE_INT: begin
                if (is_digit(ch)) begin
                    mode_next = MODE_INT;
                    held_next = ch;
                end
            end
            MODE_EQ: begin
                if (ch == CH_GT) begin
                    mode_next = MODE_IDLE;
                    held_next = 8'h00;
                end
            end
            MODE_ERR: begin
                mode_next = (ch == CH_END) ? MODE_IDLE : MODE_ERR;
                held_next = 8'h00;
            end
            default: begin
                mode_next = idle_mode;
                held_next = idle_held;
            end
        endcase
    end

    // Results produced by this byte, before burst marking.
    always_comb begin
        raw_n = 2'd0;
        raw0  = idle_res;
        raw1  = idle_res;
        unique case (mode_reg)
            MODE_ID: begin
                raw0 = '{kind: K_ID, tok_char: held_reg, token_last: !word_char,
                         burst_last: 1'b0};
                raw_n = (!word_char && idle_emit) ? 2'd2 : 2'd1;
            end
            MODE_INT: begin
                raw0 = '{kind: K_INT, tok_char: held_reg, token_last: !is_digit(ch),
                         burst_last: 1'b0};
                raw_n = (!is_digit(ch) && idle_emit) ? 2'd2 : 2'd1;
            end
            MODE_EQ: begin
                if (ch == CH_GT) begin
                    raw0  = '{kind: K_ARROW, tok_char: CH_EQ, token_last: 1'b0,
                              burst_last: 1'b0};
                    raw1  = '{kind: K_ARROW, tok_char: CH_GT, token_last: 1'b1,
                              burst_last: 1'b0};
                    raw_n = 2'd2;
                end else begin
                    raw0  = '{kind: K_EQUALS, tok_char: CH_EQ, token_last: 1'b1,
                              burst_last: 1'b0};
                    raw_n = idle_emit ? 2'd2 : 2'd1;
                end
            end
            MODE_ERR: begin
                raw_n = 2'd0;
            end
            default: begin
                raw0  = idle_res;
                raw_n = idle_emit ? 2'd1 : 2'd0;
            end
        endcase
    end

    // Flag the last result of the burst.
    always_comb begin
        res0            = raw0;
        res1            = raw1;
        res0.burst_last = (raw_n == 2'd1);
        res1.burst_last = (raw_n == 2'd2);
        push_n          = fire ? raw_n : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            held_reg <= 8'h00;
        end else if (fire) begin
            mode_reg <= mode_next;
            held_reg <= held_next;
        end
    end

    `BTOK_ASSERT_IMPLIES(a_err_holds_nothing, aclk, aresetn, mode_reg == MODE_ERR,
        held_reg == 8'h00)
    `BTOK_ASSERT_IMPLIES(a_err_silent, aclk, aresetn, fire && (mode_reg == MODE_ERR),
        push_n == 2'd0)
    `BTOK_ASSERT_NEXT(a_eof_to_idle, aclk, aresetn,
        fire && (ch == CH_END), mode_reg == MODE_IDLE)

endmodule

// ===== rtl/core/byte_stream_tokenizer_core.sv =====
// Channel  Dir  Ports                                                        Beat
// s_       in   s_valid s_ready s_ch                                         one source byte
// m_       out  m_valid m_ready m_kind m_tok_char m_token_last m_burst_last  one result
//
// A byte lands in the input register at acceptance and is lexed once the queue can take two results,
// writing zero, one or two results into a four-entry result queue; a result is
// registered in the queue before it appears on m_.
// One byte per cycle is taken while the queue holds two results or fewer; the
// result side drains one beat per cycle while m_ready is high.
// Reset returns the lexer to idle with nothing held and empties the queue.
// s_ready depends only on registers, never on m_ready.
`include "byte_stream_tokenizer_core_defines.svh"

module byte_stream_tokenizer_core
    import btok_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ch,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_kind,
    output logic [7:0] m_tok_char,
    output logic       m_token_last,
    output logic       m_burst_last
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_ch_reg;
    logic        room_two;
    logic        fire;
    logic [1:0]  push_n;
    result_t     res0, res1;
    result_t     head;

    // The buffered byte is lexed once the queue can take two results.
    assign fire    = in_valid_reg && room_two;
    assign s_ready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_ch_reg <= s_ch;
        end
    end

    btok_lexer u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .ch      (in_ch_reg),
        .push_n  (push_n),
        .res0    (res0),
        .res1    (res1)
    );

    btok_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_n     (push_n),
        .push_data0 (res0),
        .push_data1 (res1),
        .room_two   (room_two),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_data   (head)
    );

    assign m_kind       = head.kind;
    assign m_tok_char   = head.tok_char;
    assign m_token_last = head.token_last;
    assign m_burst_last = head.burst_last;

    `BTOK_ASSERT_NEXT(a_accept_loads, aclk, aresetn, s_valid && s_ready, in_valid_reg)

endmodule
